### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int TEXT_CAPACITY = 512;

  localparam logic [8:0] MAX_UNITS_RESET =
    (TEXT_CAPACITY - 1 > 511) ? 9'd511 : 9'(TEXT_CAPACITY - 1);

  localparam logic [15:0] BAD_UNIT = 16'h003F;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PUSH    = 3;

  // pending byte counts
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } unit_t;

  typedef struct packed {
    logic [1:0]  count;
    unit_t [2:0] units;
  } push_t;

endpackage

### rtl/utf8_to_utf16_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// UTF-8 byte stream to UTF-16 basic-plane code unit stream.
// ----------------------------------------------------------------------------
// One byte per input transaction, zero byte ends the text and gives a zero
// word with last_unit set. A byte is taken every cycle while each byte gives
// at most one unit and the output takes each unit; a byte giving two or three
// units (a sequence cut by the terminator) writes them all into the queue at
// once. Pace is set by the four-entry result queue: the byte in the decode
// register is decoded only while the queue holds at most one unit, and a new
// byte is taken when that register is empty or its byte is being decoded.
// Decoded units are offered from the queue head. max_units is written through
// the cfg channel, always ready, and should only change while the block is idle.
module utf8_to_utf16_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        last_unit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  logic [8:0]       max_units;
  logic             room;
  u8u16_pkg::push_t push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= u8u16_pkg::MAX_UNITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_units <= cfg_data;
    end
  end

  u8u16_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .max_units (max_units),
    .room      (room),
    .push      (push)
  );

  u8u16_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

endmodule

### rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Input register, sequence state and per-byte decode into up to three units.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        text_byte,
  input  logic [8:0]        max_units,
  input  logic              room,
  output u8u16_pkg::push_t  push
);

  logic       held;
  logic [7:0] byte_reg;
  logic       consume;

  logic [1:0] pending_needed, pending_needed_next;
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] first_follow_byte, first_follow_byte_next;
  logic       have_first_follow, have_first_follow_next;
  logic [9:0] units_emitted, units_emitted_next;

  assign consume  = held && room;
  assign in_ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      byte_reg <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_needed    <= u8u16_pkg::PEND_NONE;
      lead_byte         <= '0;
      first_follow_byte <= '0;
      have_first_follow <= 1'b0;
      units_emitted     <= '0;
    end else if (consume) begin
      pending_needed    <= pending_needed_next;
      lead_byte         <= lead_byte_next;
      first_follow_byte <= first_follow_byte_next;
      have_first_follow <= have_first_follow_next;
      units_emitted     <= units_emitted_next;
    end
  end

  always_comb begin
    logic [1:0]  cnt;
    logic [9:0]  ue;
    logic [15:0] val;
    logic [9:0]  lim;
    cnt = 2'd0;
    ue  = units_emitted;
    val = '0;
    lim = {1'b0, max_units};
    push.units = '0;
    pending_needed_next    = pending_needed;
    lead_byte_next         = lead_byte;
    first_follow_byte_next = first_follow_byte;
    have_first_follow_next = have_first_follow;

    if (byte_reg == 8'd0) begin
      if (pending_needed != u8u16_pkg::PEND_NONE) begin
        if (ue < lim) begin
          push.units[cnt] = '{code: u8u16_pkg::BAD_UNIT, last: 1'b0};
          cnt = cnt + 2'd1;
          ue  = ue + 10'd1;
        end
        if (have_first_follow && ue < lim) begin
          val = first_follow_byte[7] ? u8u16_pkg::BAD_UNIT : {8'd0, first_follow_byte};
          push.units[cnt] = '{code: val, last: 1'b0};
          cnt = cnt + 2'd1;
          ue  = ue + 10'd1;
        end
      end
      push.units[cnt] = '{code: 16'd0, last: 1'b1};
      cnt = cnt + 2'd1;
      ue  = '0;
      pending_needed_next    = u8u16_pkg::PEND_NONE;
      lead_byte_next         = '0;
      first_follow_byte_next = '0;
      have_first_follow_next = 1'b0;
    end else if (pending_needed == u8u16_pkg::PEND_NONE) begin
      if (ue < lim) begin
        if (!byte_reg[7]) begin
          push.units[0] = '{code: {8'd0, byte_reg}, last: 1'b0};
          cnt = 2'd1;
          ue  = ue + 10'd1;
        end else if (byte_reg[7:5] == 3'b110) begin
          lead_byte_next         = byte_reg;
          pending_needed_next    = u8u16_pkg::PEND_ONE;
          have_first_follow_next = 1'b0;
        end else if (byte_reg[7:4] == 4'b1110) begin
          lead_byte_next         = byte_reg;
          pending_needed_next    = u8u16_pkg::PEND_TWO;
          have_first_follow_next = 1'b0;
        end else begin
          push.units[0] = '{code: u8u16_pkg::BAD_UNIT, last: 1'b0};
          cnt = 2'd1;
          ue  = ue + 10'd1;
        end
      end
    end else if (pending_needed == u8u16_pkg::PEND_TWO) begin
      first_follow_byte_next = byte_reg;
      have_first_follow_next = 1'b1;
      pending_needed_next    = u8u16_pkg::PEND_ONE;
    end else begin
      if (have_first_follow) begin
        val = {lead_byte[3:0], first_follow_byte[5:0], byte_reg[5:0]};
      end else begin
        val = {5'd0, lead_byte[4:0], byte_reg[5:0]};
      end
      if (ue < lim) begin
        push.units[0] = '{code: val, last: 1'b0};
        cnt = 2'd1;
        ue  = ue + 10'd1;
      end
      pending_needed_next    = u8u16_pkg::PEND_NONE;
      lead_byte_next         = '0;
      first_follow_byte_next = '0;
      have_first_follow_next = 1'b0;
    end

    units_emitted_next = ue;
    push.count = consume ? cnt : 2'd0;
  end

endmodule

### rtl/u8u16_outq.sv
// ----------------------------------------------------------------------------
// u8u16_outq
// Small result queue taking up to three units a cycle and giving one out.
// ----------------------------------------------------------------------------
module u8u16_outq (
  input  logic              clk,
  input  logic              rst,
  input  u8u16_pkg::push_t  push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              last_unit
);

  u8u16_pkg::unit_t entries [u8u16_pkg::QUEUE_DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= 3'(u8u16_pkg::QUEUE_DEPTH - u8u16_pkg::MAX_PUSH);
  assign code_unit = entries[rptr].code;
  assign last_unit = entries[rptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.count;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < u8u16_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push.count) begin
        entries[wptr + 2'(i)] <= push.units[i];
      end
    end
  end

endmodule

### bench/utf8_to_utf16_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top_tb
// Feeds UTF-8 texts byte by byte through the valid/ready input, with random
// gaps on both sides and a long output stall, and compares every code unit
// against a decoder model kept in the bench. Directed bytes cover the lead
// classes, invalid bytes, sequences cut by the terminator and truncation at
// several unit limits; random texts follow under a range of limits.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top_tb;

  localparam logic [7:0] TERM_BYTE  = 8'h00;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [2:0] LEAD2_TAG  = 3'b110;
  localparam logic [3:0] LEAD3_TAG  = 4'b1110;
  localparam logic [1:0] FOLLOW_TAG = 2'b10;
  localparam int LONG_HOLD   = 100;
  localparam int STUCK_LIMIT = 1000;
  localparam int IDLE_SETTLE = 12;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        last_unit;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  feed_t               byte_q[$];
  u8u16_pkg::unit_t    units_due[$];
  int    backlog = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    hold_req = 0;
  bit    send_idle = 1'b0;
  bit    recv_idle = 1'b0;
  bit    drain_next = 1'b0;

  // decoder model state
  logic [1:0] seq_need;
  logic [7:0] seq_lead;
  logic [7:0] seq_mid;
  logic       seq_has_mid;
  logic [9:0] text_count;
  logic [8:0] unit_limit;

  utf8_to_utf16_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---- decoder model ----
  task automatic clear_sequence();
    seq_need    = u8u16_pkg::PEND_NONE;
    seq_lead    = '0;
    seq_mid     = '0;
    seq_has_mid = 1'b0;
  endtask

  task automatic put_data(input logic [15:0] u);
    if (text_count >= {1'b0, unit_limit}) return;
    units_due.insert(units_due.size(), u8u16_pkg::unit_t'{code: u, last: 1'b0});
    text_count = text_count + 10'd1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (b == TERM_BYTE) begin
      if (seq_need != u8u16_pkg::PEND_NONE) begin
        put_data(u8u16_pkg::BAD_UNIT);
        if (seq_has_mid)
          put_data(seq_mid < ASCII_TOP ? {8'h00, seq_mid} : u8u16_pkg::BAD_UNIT);
      end
      units_due.insert(units_due.size(), u8u16_pkg::unit_t'{code: 16'h0000, last: 1'b1});
      clear_sequence();
      text_count = '0;
    end else if (seq_need == u8u16_pkg::PEND_NONE) begin
      if (text_count < {1'b0, unit_limit}) begin
        if (b < ASCII_TOP) begin
          put_data({8'h00, b});
        end else if (b[7:5] == LEAD2_TAG) begin
          seq_lead    = b;
          seq_need    = u8u16_pkg::PEND_ONE;
          seq_has_mid = 1'b0;
        end else if (b[7:4] == LEAD3_TAG) begin
          seq_lead    = b;
          seq_need    = u8u16_pkg::PEND_TWO;
          seq_has_mid = 1'b0;
        end else begin
          put_data(u8u16_pkg::BAD_UNIT);
        end
      end
    end else if (seq_need == u8u16_pkg::PEND_TWO) begin
      seq_mid     = b;
      seq_has_mid = 1'b1;
      seq_need    = u8u16_pkg::PEND_ONE;
    end else begin
      if (seq_has_mid) put_data({seq_lead[3:0], seq_mid[5:0], b[5:0]});
      else put_data({5'b00000, seq_lead[4:0], b[5:0]});
      clear_sequence();
    end
  endtask

  // ---- byte driver ----
  always @(posedge clk) begin : drive_bytes
    feed_t nxt;
    int    gap_left;
    if (rst) begin
      in_valid  <= 1'b0;
      text_byte <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) gap_left = pick_gap(send_idle);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0 &&
                     (!byte_q[0].drain || (!in_valid && backlog == 0))) begin
          nxt = byte_q.pop_front();
          in_valid  <= 1'b1;
          text_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- output ready with random gaps and long hold ----
  always @(posedge clk) begin : drive_ready
    int hold_left;
    int hold_ack;
    int ready_gap;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_ack  = 0;
      ready_gap = 0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (out_valid && out_ready) ready_gap = pick_gap(recv_idle);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---- monitor: check units, track config, predict from accepted bytes ----
  always @(posedge clk) begin : watch_ports
    u8u16_pkg::unit_t want;
    if (rst) begin
      clear_sequence();
      text_count = '0;
      unit_limit = u8u16_pkg::MAX_UNITS_RESET;
      backlog <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (units_due.size() == 0) begin
          report($sformatf("unexpected unit %h last %b", code_unit, last_unit));
        end else begin
          want = units_due.pop_front();
          if (code_unit !== want.code)
            report($sformatf("code_unit %h, expected %h", code_unit, want.code));
          if (last_unit !== want.last)
            report($sformatf("last_unit %b, expected %b", last_unit, want.last));
        end
      end
      if (cfg_valid && cfg_ready) unit_limit = cfg_data;
      if (in_valid && in_ready) decode_byte(text_byte);
      backlog <= units_due.size();
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ----
  task automatic add_byte(input logic [7:0] b);
    byte_q.insert(byte_q.size(), feed_t'{data: b, drain: drain_next});
    drain_next = 1'b0;
  endtask

  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return {FOLLOW_TAG, 6'($urandom)};
  endfunction

  task automatic add_text(input int n_chars);
    int r;
    bit cut;
    cut = 1'b0;
    for (int i = 0; i < n_chars && !cut; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        add_byte(8'($urandom_range(1, 127)));
      end else if (r < 60) begin
        add_byte({LEAD2_TAG, 5'($urandom)});
        add_byte(follow_byte());
      end else if (r < 80) begin
        add_byte({LEAD3_TAG, 4'($urandom)});
        add_byte(follow_byte());
        add_byte(follow_byte());
      end else if (r < 90) begin
        add_byte(8'($urandom_range(1, 255)));
      end else if (r < 95) begin
        add_byte(r[0] ? 8'($urandom_range(8'h80, 8'hBF)) : 8'($urandom_range(8'hF0, 8'hFF)));
      end else begin
        // lead cut short by the terminator
        cut = 1'b1;
        if (r[0]) begin
          add_byte({LEAD2_TAG, 5'($urandom)});
        end else begin
          add_byte({LEAD3_TAG, 4'($urandom)});
          if ($urandom_range(0, 1) != 0) add_byte(8'($urandom_range(1, 255)));
        end
      end
    end
    add_byte(TERM_BYTE);
  endtask

  task automatic add_texts(input int n_bytes);
    while (byte_q.size() < n_bytes) begin
      drain_next = drain_next || ($urandom_range(0, 9) == 0);
      add_text($urandom_range(0, 4) != 0 ? $urandom_range(1, 6) : $urandom_range(7, 16));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || backlog != 0);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [8:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input logic [8:0] limit, input bit s_idle, input bit r_idle);
    wait_idle();
    write_limit(limit);
    @(negedge clk);
    send_idle = s_idle;
    recv_idle = r_idle;
  endtask

  task automatic add_list(input logic [7:0] list[]);
    foreach (list[i]) add_byte(list[i]);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lead classes, invalid bytes, cut sequences at the default limit
    add_list('{8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hDF, 8'hFF, 8'hE2, 8'h82, 8'hAC,
               8'hEF, 8'hFF, 8'hFF, 8'h80, 8'hF0, 8'hFF, 8'h00,
               8'hC5, 8'h00, 8'hE4, 8'h41, 8'h00, 8'hE4, 8'h9F, 8'h00});

    // truncation
    start_phase(9'd0, 1'b0, 1'b0);
    add_list('{8'h41, 8'hC3, 8'hA9, 8'hE4, 8'h00});
    start_phase(9'd2, 1'b0, 1'b0);
    add_list('{8'h41, 8'h42, 8'h43, 8'hE2, 8'h82, 8'hAC, 8'h00,
               8'hC3, 8'hA9, 8'hE2, 8'h82, 8'h00});
    start_phase(9'd1, 1'b0, 1'b0);
    add_list('{8'hE4, 8'h9F, 8'h00});

    // long output stall with the sender still pushing
    start_phase(9'd511, 1'b0, 1'b0);
    hold_req = hold_req + 1;
    add_texts(15);
    drain_next = 1'b1;
    add_texts(35);

    start_phase(9'd511, 1'b1, 1'b1);
    add_texts(20);
    start_phase(9'd3, 1'b1, 1'b1);
    add_texts(20);
    start_phase(9'd1, 1'b1, 1'b0);
    add_texts(15);
    start_phase(9'd0, 1'b0, 1'b1);
    add_texts(10);
    start_phase(9'($urandom_range(4, 510)), 1'b1, 1'b1);
    add_texts(20);
    start_phase(9'd6, 1'b1, 1'b1);
    add_texts(20);

    wait_idle();
    if (units_due.size() != 0) report($sformatf("%0d units never arrived", units_due.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
